/* rtl/qtnl_pkg.sv */
// Package for the quadtree tile node lookup unit.
// Holds table sizes, register indexes, command codes and the sequencer state type.
// No dependencies.
`default_nettype none

package qtnl_pkg;

    // Table geometry
    localparam int unsigned NODE_COUNT = 65536;
    localparam int unsigned MAX_LEVEL  = 24;
    localparam int unsigned NODE_AW    = 16;
    localparam int unsigned TABLE_AW   = NODE_AW + 2;
    localparam int unsigned TABLE_DEPTH = NODE_COUNT * 4;

    // Field widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LEVEL_W = 5;
    localparam int unsigned LAT_W   = 20;
    localparam int unsigned LNG_W   = 21;
    localparam int unsigned ADDR_W  = 5;

    // All-ones node index marks a missing node
    localparam logic [WORD_W-1:0] NO_NODE = '1;

    // Request commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_ROOT_L1    = 3'd0;
    localparam logic [2:0] REG_ROOT_L2    = 3'd1;
    localparam logic [2:0] REG_ROOT_L3    = 3'd2;
    localparam logic [2:0] REG_ROOT_WEST  = 3'd3;
    localparam logic [2:0] REG_ROOT_EAST  = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK
    } state_t;

endpackage

`default_nettype wire

/* rtl/quadtree_tile_node_lookup_unit.sv */
// Quadtree tile node lookup unit: child table, root registers and walk sequencer.
// Depends on qtnl_pkg.
//
// A write request gives its result the cycle after acceptance. A lookup of level 1
// to 3, a bad level or an out-of-range longitude half answers from the prep state;
// a lookup of level 4 or deeper goes on to the walk state and makes one child-table
// read per level below four; a walk that meets a missing node ends early.
// Throughput: one request at a time; the next is taken once the result is taken.
// Reset clears the sequencer, output valid and root registers (all ones); the
// child table is not cleared and holds garbage until written.
`default_nettype none

module quadtree_tile_node_lookup_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [15:0]                   entry_node,
    input  wire logic [1:0]                    entry_slot,
    input  wire logic [qtnl_pkg::WORD_W-1:0]   entry_child,
    input  wire logic [qtnl_pkg::LEVEL_W-1:0]  level,
    input  wire logic [qtnl_pkg::LAT_W-1:0]    lat_index,
    input  wire logic [qtnl_pkg::LNG_W-1:0]    lng_index,

    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [qtnl_pkg::WORD_W-1:0]        node_index,
    output logic                               found,

    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [qtnl_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import qtnl_pkg::*;

    // Sequencer and request registers
    state_t               state_reg, state_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [LAT_W-1:0]     lat_reg, lat_next;
    logic [LNG_W-1:0]     lng_reg, lng_next;
    logic [WORD_W-1:0]    cur_reg, cur_next;
    logic [LEVEL_W-1:0]   step_reg, step_next;
    logic                 use_mem_reg, use_mem_next;

    // Result registers
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]    node_index_reg, node_index_next;
    logic                 found_reg, found_next;

    // Root registers
    logic [WORD_W-1:0]    root_l1_reg, root_l2_reg, root_l3_reg;
    logic [WORD_W-1:0]    root_west_reg, root_east_reg;

    // Child table
    logic [WORD_W-1:0]    table_mem [0:TABLE_DEPTH-1];
    logic [WORD_W-1:0]    mem_q_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [TABLE_AW-1:0]  mem_raddr;

    // Decode and walk helpers
    logic                 accept;
    logic                 cfg_write;
    logic [2:0]           reg_idx;
    logic                 lvl_bad;
    logic                 lvl_shallow;
    logic [LEVEL_W-1:0]   shamt;
    logic [LNG_W-1:0]     half;
    logic                 half_bad;
    logic [WORD_W-1:0]    cur_word;
    logic                 walk_done;
    logic                 walk_stop;
    logic [LEVEL_W-1:0]   bit_idx;
    logic [WORD_W-1:0]    shallow_root;

    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign node_index = node_index_reg;
    assign found      = found_reg;
    assign pready     = 1'b1;

    // APB decode
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            REG_ROOT_L1:   prdata = root_l1_reg;
            REG_ROOT_L2:   prdata = root_l2_reg;
            REG_ROOT_L3:   prdata = root_l3_reg;
            REG_ROOT_WEST: prdata = root_west_reg;
            REG_ROOT_EAST: prdata = root_east_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_l1_reg   <= NO_NODE;
            root_l2_reg   <= NO_NODE;
            root_l3_reg   <= NO_NODE;
            root_west_reg <= NO_NODE;
            root_east_reg <= NO_NODE;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_ROOT_L1:   root_l1_reg   <= pwdata;
                REG_ROOT_L2:   root_l2_reg   <= pwdata;
                REG_ROOT_L3:   root_l3_reg   <= pwdata;
                REG_ROOT_WEST: root_west_reg <= pwdata;
                REG_ROOT_EAST: root_east_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    // Level classification, done in the prep cycle
    assign lvl_bad     = (level_reg == '0) || (level_reg > LEVEL_W'(MAX_LEVEL));
    assign lvl_shallow = (level_reg < LEVEL_W'(4));
    assign shamt       = level_reg - LEVEL_W'(4);
    assign half        = lng_reg >> shamt;
    assign half_bad    = |half[LNG_W-1:1];

    always_comb
    begin
        case (level_reg[1:0])
            2'd1:    shallow_root = root_l1_reg;
            2'd2:    shallow_root = root_l2_reg;
            2'd3:    shallow_root = root_l3_reg;
            default: shallow_root = NO_NODE;
        endcase
    end

    // Walk step: current node comes from the root on the first step, then from the table read of the previous step
    assign cur_word  = use_mem_reg ? mem_q_reg : cur_reg;
    assign walk_done = (step_reg == '0);
    assign walk_stop = (cur_word == NO_NODE) || (cur_word >= WORD_W'(NODE_COUNT));
    assign bit_idx   = step_reg - LEVEL_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_LOOKUP))
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (lvl_bad || lvl_shallow || half_bad)
                    state_next = ST_IDLE;
                else
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_done || walk_stop)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result updates
    always_comb
    begin
        level_next      = level_reg;
        lat_next        = lat_reg;
        lng_next        = lng_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        use_mem_next    = use_mem_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        node_index_next = node_index_reg;
        found_next      = found_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = {cur_word[NODE_AW-1:0], lat_reg[bit_idx], lng_reg[bit_idx]};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        mem_we          = ({1'b0, entry_node} < 17'(NODE_COUNT));
                        out_valid_next  = 1'b1;
                        node_index_next = '0;
                        found_next      = 1'b0;
                    end
                    else
                    begin
                        level_next = level;
                        lat_next   = lat_index;
                        lng_next   = lng_index;
                    end
                end
            end
            ST_PREP:
            begin
                if (lvl_bad || half_bad)
                begin
                    out_valid_next  = 1'b1;
                    node_index_next = NO_NODE;
                    found_next      = 1'b0;
                end
                else if (lvl_shallow)
                begin
                    out_valid_next  = 1'b1;
                    node_index_next = shallow_root;
                    found_next      = (shallow_root != NO_NODE);
                end
                else
                begin
                    cur_next     = half[0] ? root_east_reg : root_west_reg;
                    step_next    = shamt;
                    use_mem_next = 1'b0;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    out_valid_next  = 1'b1;
                    node_index_next = cur_word;
                    found_next      = (cur_word != NO_NODE);
                end
                else if (walk_stop)
                begin
                    out_valid_next  = 1'b1;
                    node_index_next = NO_NODE;
                    found_next      = 1'b0;
                end
                else
                begin
                    mem_re       = 1'b1;
                    step_next    = bit_idx;
                    use_mem_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            use_mem_reg   <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            use_mem_reg   <= use_mem_next;
            step_reg      <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        level_reg      <= level_next;
        lat_reg        <= lat_next;
        lng_reg        <= lng_next;
        cur_reg        <= cur_next;
        node_index_reg <= node_index_next;
        found_reg      <= found_next;
    end

    // Child table: one write port from requests, one registered read port for the walk
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[{entry_node, entry_slot}] <= entry_child;
        if (mem_re)
            mem_q_reg <= table_mem[mem_raddr];
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the quadtree tile node lookup unit: root registers, child-table writes and walks.
// Tracks its own copy of the roots and written child slots to predict every answer.
// Depends on qtnl_pkg and quadtree_tile_node_lookup_unit.
`timescale 1ns / 100ps

module tb_top;

    import qtnl_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned TREE_SIZE      = 32;
    localparam int unsigned PHASE_ITEMS    = 250;

    typedef struct {
        logic                cmd;
        logic [15:0]         node;
        logic [1:0]          slot;
        logic [WORD_W-1:0]   child;
        logic [LEVEL_W-1:0]  lvl;
        logic [LAT_W-1:0]    lat;
        logic [LNG_W-1:0]    lng;
    } tile_req_t;

    typedef struct {
        logic [WORD_W-1:0] node;
        logic              found;
    } tile_answer_t;

    // DUT signals
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 cmd = CMD_WRITE;
    logic [15:0]          entry_node = '0;
    logic [1:0]           entry_slot = '0;
    logic [WORD_W-1:0]    entry_child = '0;
    logic [LEVEL_W-1:0]   level = '0;
    logic [LAT_W-1:0]     lat_index = '0;
    logic [LNG_W-1:0]     lng_index = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [WORD_W-1:0]    node_index;
    logic                 found;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow state of the block
    logic [WORD_W-1:0]    root_cfg [5];
    logic [WORD_W-1:0]    child_words [int unsigned];
    tile_answer_t         pending_answers [$];
    logic [15:0]          tree_nodes [$];

    // Traffic shaping
    int unsigned          send_gap_pct = 0;
    int unsigned          sink_stall_pct = 0;
    int unsigned          long_hold_req = 0;
    int unsigned          hold_left = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          mismatch_count = 0;

    quadtree_tile_node_lookup_unit uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .entry_node  (entry_node),
        .entry_slot  (entry_slot),
        .entry_child (entry_child),
        .level       (level),
        .lat_index   (lat_index),
        .lng_index   (lng_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .node_index  (node_index),
        .found       (found),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Walk predictor; flags a read of a child slot that was never loaded
    function automatic logic [WORD_W-1:0] trace_tile(input logic [LEVEL_W-1:0] lvl,
                                                     input logic [LAT_W-1:0] lat,
                                                     input logic [LNG_W-1:0] lng,
                                                     output bit hits_blank);
        logic [WORD_W-1:0] cur;
        logic [LNG_W-1:0]  half;
        int unsigned       key;
        hits_blank = 1'b0;
        if (lvl == 0 || lvl > MAX_LEVEL)
            return NO_NODE;
        if (lvl == 1)
            return root_cfg[REG_ROOT_L1];
        if (lvl == 2)
            return root_cfg[REG_ROOT_L2];
        if (lvl == 3)
            return root_cfg[REG_ROOT_L3];
        half = lng >> (lvl - 4);
        if (half > 1)
            return NO_NODE;
        cur = half[0] ? root_cfg[REG_ROOT_EAST] : root_cfg[REG_ROOT_WEST];
        for (int s = lvl - 4; s > 0; s--)
        begin
            if (cur == NO_NODE || cur >= NODE_COUNT)
                return NO_NODE;
            key = 32'({cur[15:0], lat[s-1], lng[s-1]});
            if (!child_words.exists(key))
            begin
                hits_blank = 1'b1;
                return NO_NODE;
            end
            cur = child_words[key];
        end
        return cur;
    endfunction

    function automatic tile_req_t write_req(input logic [15:0] node, input logic [1:0] slot,
                                            input logic [WORD_W-1:0] child);
        tile_req_t r;
        r.cmd   = CMD_WRITE;
        r.node  = node;
        r.slot  = slot;
        r.child = child;
        r.lvl   = LEVEL_W'($urandom);
        r.lat   = LAT_W'($urandom);
        r.lng   = LNG_W'($urandom);
        return r;
    endfunction

    // Lookup request; a walk into an unloaded slot is cut back to level 4
    function automatic tile_req_t lookup_req(input int unsigned lvl,
                                             input int unsigned lat,
                                             input int unsigned lng);
        tile_req_t         r;
        bit                blank;
        r.cmd   = CMD_LOOKUP;
        r.node  = 16'($urandom);
        r.slot  = 2'($urandom);
        r.child = $urandom;
        r.lvl   = LEVEL_W'(lvl);
        r.lat   = LAT_W'(lat);
        r.lng   = LNG_W'(lng);
        void'(trace_tile(r.lvl, r.lat, r.lng, blank));
        if (blank)
            r.lvl = LEVEL_W'(4);
        return r;
    endfunction

    // Child value for tree slots: mostly links inside the tree
    function automatic logic [WORD_W-1:0] pick_child();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return {16'h0, tree_nodes[$urandom_range(tree_nodes.size() - 1)]};
        if (roll < 80)
            return NO_NODE;
        if (roll < 90)
            return $urandom_range(32'hFFFF_FFFE, NODE_COUNT);
        return $urandom;
    endfunction

    // Send one request, then log its predicted answer
    task automatic issue_request(input tile_req_t r);
        tile_answer_t ans;
        bit           blank;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= r.cmd;
        entry_node  <= r.node;
        entry_slot  <= r.slot;
        entry_child <= r.child;
        level       <= r.lvl;
        lat_index   <= r.lat;
        lng_index   <= r.lng;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (r.cmd == CMD_WRITE)
        begin
            if (r.node < NODE_COUNT)
                child_words[32'({r.node, r.slot})] = r.child;
            ans.node  = '0;
            ans.found = 1'b0;
        end
        else
        begin
            ans.node  = trace_tile(r.lvl, r.lat, r.lng, blank);
            ans.found = (ans.node != NO_NODE);
        end
        pending_answers.push_back(ans);
    endtask

    // Drop the request line and wait for every outstanding answer
    task automatic wait_for_answers();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup, access, then idle
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx <= REG_ROOT_EAST)
            root_cfg[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_check(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== root_cfg[idx])
        begin
            $error("prdata[%0d] expected %h actual %h", idx, root_cfg[idx], prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_all_roots();
        for (int i = REG_ROOT_L1; i <= REG_ROOT_EAST; i++)
            cfg_check(3'(i));
    endtask

    // New root set for a phase, mostly nodes inside the tree
    task automatic reseat_roots();
        logic [31:0] val;
        int unsigned roll;
        for (int i = REG_ROOT_L1; i <= REG_ROOT_EAST; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                val = {16'h0, tree_nodes[$urandom_range(tree_nodes.size() - 1)]};
            else if (roll < 75)
                val = NO_NODE;
            else if (roll < 85)
                val = $urandom_range(32'hFFFF_FFFE, NODE_COUNT);
            else
                val = $urandom;
            cfg_write(3'(i), val);
        end
        // unmapped index must leave the roots alone
        cfg_write(3'($urandom_range(7, 5)), $urandom);
        check_all_roots();
    endtask

    // Roots come out of reset as no-node
    task automatic test_reset_state();
        check_all_roots();
        issue_request(lookup_req(1, $urandom, $urandom));
        issue_request(lookup_req(2, $urandom, $urandom));
        issue_request(lookup_req(3, $urandom, $urandom));
        issue_request(lookup_req(4, $urandom, 0));
        issue_request(lookup_req(4, $urandom, 1));
        issue_request(lookup_req(9, 0, 0));
        wait_for_answers();
    endtask

    // Field extremes, invalid levels, shallow levels and every walk exit
    task automatic test_directed_walks();
        cfg_write(REG_ROOT_L1, 32'h0000_0000);
        cfg_write(REG_ROOT_L2, 32'hFFFF_FFFE);
        cfg_write(REG_ROOT_L3, 32'h1234_5678);
        cfg_write(REG_ROOT_WEST, 32'h0000_0000);
        cfg_write(REG_ROOT_EAST, 32'h0000_FFFF);
        cfg_write(3'd5, 32'h0000_0001);
        cfg_write(3'd7, 32'h0000_0002);
        check_all_roots();

        issue_request(write_req(16'h0000, 2'd0, 32'h0000_FFFF));
        issue_request(write_req(16'h0000, 2'd1, NO_NODE));
        issue_request(write_req(16'h0000, 2'd2, 32'h0001_0000));
        issue_request(write_req(16'h0000, 2'd3, 32'h0000_0000));
        issue_request(write_req(16'hFFFF, 2'd0, 32'h0000_0000));
        issue_request(write_req(16'hFFFF, 2'd1, 32'hDEAD_BEEF));
        issue_request(write_req(16'hFFFF, 2'd2, 32'h0000_FFFF));
        issue_request(write_req(16'hFFFF, 2'd3, 32'h8000_0000));

        // level zero and too deep
        issue_request(lookup_req(0, $urandom, $urandom));
        issue_request(lookup_req(25, 0, 0));
        issue_request(lookup_req(31, $urandom, $urandom));
        // shallow levels ignore the indexes; level 4 picks the west or east root
        issue_request(lookup_req(1, $urandom, $urandom));
        issue_request(lookup_req(2, $urandom, $urandom));
        issue_request(lookup_req(3, $urandom, $urandom));
        issue_request(lookup_req(4, $urandom, 0));
        issue_request(lookup_req(4, $urandom, 1));
        // longitude half out of range
        issue_request(lookup_req(4, 0, 2));
        // found, missing child, final node beyond table
        issue_request(lookup_req(5, 0, 0));
        issue_request(lookup_req(5, 0, 1));
        issue_request(lookup_req(5, 1, 0));
        // meets a node beyond the table mid-walk, which ends the walk
        issue_request(lookup_req(6, 2, 0));
        // full depth
        issue_request(lookup_req(24, 0, 0));
        issue_request(lookup_req(24, 'hFFFFF, 'h1FFFFF));
        wait_for_answers();
    endtask

    // Load every slot of a small node set so deep walks stay on loaded slots
    task automatic test_build_tree();
        tree_nodes.push_back(16'h0000);
        tree_nodes.push_back(16'hFFFF);
        while (tree_nodes.size() < TREE_SIZE)
            tree_nodes.push_back(16'($urandom));
        foreach (tree_nodes[i])
            for (int s = 0; s < 4; s++)
                issue_request(write_req(tree_nodes[i], 2'(s), pick_child()));
        wait_for_answers();
    endtask

    // Mixed slot updates and lookups, mostly walks below level 4
    task automatic test_random_traffic(input int unsigned count, input int unsigned gap_pct,
                                       input int unsigned stall_pct);
        int unsigned        roll;
        logic [15:0]        node;
        int unsigned        lvl;
        int unsigned        lat;
        int unsigned        lng;
        reseat_roots();
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
        begin
            if ($urandom_range(99) < 20)
            begin
                if ($urandom_range(4) != 0)
                    node = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
                else
                    node = 16'($urandom);
                issue_request(write_req(node, 2'($urandom), pick_child()));
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                    lvl = $urandom_range(1) ? 0 : $urandom_range(31, 25);
                else if (roll < 15)
                    lvl = $urandom_range(4, 1);
                else
                    lvl = $urandom_range(24, 5);
                lat = $urandom;
                lng = $urandom;
                if (lvl >= 4 && $urandom_range(99) < 85)
                    lng = lng & ((32'd1 << (lvl - 3)) - 1);
                issue_request(lookup_req(lvl, lat, lng));
            end
        end
        wait_for_answers();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // Long result stall while requests keep coming, so the input backs up
    task automatic test_backpressure();
        reseat_roots();
        long_hold_req = LONG_HOLD;
        repeat (40)
            issue_request(lookup_req($urandom_range(24, 5), $urandom,
                                     $urandom_range(1)));
        wait_for_answers();
    endtask

    // Result checker and result-side stall control
    initial
    begin
        tile_answer_t exp;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("unexpected result node_index %h found %b", node_index, found);
                    mismatch_count++;
                end
                else
                begin
                    exp = pending_answers.pop_front();
                    if (node_index !== exp.node)
                    begin
                        $error("node_index expected %h actual %h", exp.node, node_index);
                        mismatch_count++;
                    end
                    if (found !== exp.found)
                    begin
                        $error("found expected %b actual %b", exp.found, found);
                        mismatch_count++;
                    end
                end
            end
            if (long_hold_req != 0)
            begin
                hold_left     = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: ends the run after too long without any handshake
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        for (int i = REG_ROOT_L1; i <= REG_ROOT_EAST; i++)
            root_cfg[i] = NO_NODE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_walks();
        test_build_tree();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 48, 0);
        test_random_traffic(PHASE_ITEMS, 0, 48);
        test_random_traffic(PHASE_ITEMS, 33, 33);
        test_backpressure();

        wait_for_answers();
        repeat (25) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/qtnl_pkg.sv
rtl/quadtree_tile_node_lookup_unit.sv
tb/tb_top.sv
